// File: rtl/osmd_pkg.sv
// object stream mips decoder: shared types and constants
// request structs, record codes, parser phases and instruction names
// no dependencies
`default_nettype none

package osmd_pkg;

  // magic number at the head of every object file
  localparam logic [7:0] MAGIC_BYTE0 = 8'd76;
  localparam logic [7:0] MAGIC_BYTE1 = 8'd97;
  localparam logic [7:0] MAGIC_BYTE2 = 8'd88;
  localparam logic [7:0] MAGIC_BYTE3 = 8'd0;

  // section type bytes
  localparam logic [31:0] SECT_TEXT = 32'd7;
  localparam logic [31:0] SECT_DATA = 32'd8;

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_VERSION = 4'd1,
    PH_COUNT   = 4'd2,
    PH_TYPE    = 4'd3,
    PH_ADDR    = 4'd4,
    PH_SIZE    = 4'd5,
    PH_BODY    = 4'd6,
    PH_STOPPED = 4'd7,
    PH_DONE    = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    REC_DATA_START = 3'd0,
    REC_TEXT_START = 3'd1,
    REC_DATA_BYTE  = 3'd2,
    REC_INSTR      = 3'd3,
    REC_STOPPED    = 3'd4
  } rec_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_MAGIC      = 3'd1,
    ERR_SECT_TYPE  = 3'd2,
    ERR_UNKNOWN_OP = 3'd3,
    ERR_RS_NZ      = 3'd4,
    ERR_SHAMT_ZERO = 3'd5,
    ERR_JR_FIELDS  = 3'd6,
    ERR_SHAMT_NZ   = 3'd7
  } err_e;

  typedef enum logic [4:0] {
    MN_ADD     = 5'd0,
    MN_ADDU    = 5'd1,
    MN_AND     = 5'd2,
    MN_NOR     = 5'd3,
    MN_OR      = 5'd4,
    MN_SLT     = 5'd5,
    MN_SLTU    = 5'd6,
    MN_SLL     = 5'd7,
    MN_SRA     = 5'd8,
    MN_SRL     = 5'd9,
    MN_SUB     = 5'd10,
    MN_SUBU    = 5'd11,
    MN_XOR     = 5'd12,
    MN_JR      = 5'd13,
    MN_SYSCALL = 5'd14,
    MN_J       = 5'd15,
    MN_JAL     = 5'd16,
    MN_ADDI    = 5'd17,
    MN_ADDIU   = 5'd18,
    MN_ANDI    = 5'd19,
    MN_LUI     = 5'd20,
    MN_ORI     = 5'd21,
    MN_SLTI    = 5'd22,
    MN_SLTIU   = 5'd23,
    MN_LBU     = 5'd24,
    MN_LHU     = 5'd25,
    MN_LW      = 5'd26,
    MN_SB      = 5'd27,
    MN_SH      = 5'd28,
    MN_SW      = 5'd29,
    MN_BEQ     = 5'd30,
    MN_BNE     = 5'd31
  } mnemonic_e;

  typedef enum logic [3:0] {
    FORM_NONE     = 4'd0,
    FORM_SHIFT    = 4'd1,
    FORM_RS       = 4'd2,
    FORM_THREE    = 4'd3,
    FORM_JUMP     = 4'd4,
    FORM_BRANCH   = 4'd5,
    FORM_LDST     = 4'd6,
    FORM_LUI      = 4'd7,
    FORM_HEX_IMM  = 4'd8,
    FORM_SIGN_IMM = 4'd9
  } form_e;

  // one input request
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       starts_file;
  } osmd_in_t;

  // one result record
  typedef struct packed {
    logic [2:0]         record_kind;
    logic [2:0]         error_code;
    logic [31:0]        item_address;
    logic [7:0]         byte_value;
    logic [4:0]         mnemonic;
    logic [3:0]         operand_form;
    logic [4:0]         reg_first;
    logic [4:0]         reg_second;
    logic [4:0]         reg_third;
    logic [4:0]         shift_amount;
    logic signed [15:0] immediate;
    logic [31:0]        target;
  } osmd_rec_t;

  // decoder result handed to the parser
  typedef struct packed {
    err_e               err;
    mnemonic_e          mnemonic;
    form_e              form;
    logic [4:0]         reg_first;
    logic [4:0]         reg_second;
    logic [4:0]         reg_third;
    logic [4:0]         shift_amount;
    logic signed [15:0] immediate;
    logic [31:0]        target;
  } osmd_dec_t;

endpackage

`default_nettype wire

// File: rtl/object_stream_mips_decoder_unit.sv
// object stream mips decoder: top level, byte-stream parser and record output
// depends on osmd_pkg and osmd_decode
//
// Usage
//   The input channel (in_valid_i / in_ready_o / in_data_i) carries one byte
//   of an object file per request. A request with starts_file set restarts
//   the parse at the first magic byte. Each request yields zero or one record
//   on the output channel (out_valid_o / out_ready_i / out_data_o): section
//   starts, data bytes, decoded instructions, or one stopped record on error.
//   Throughput: one request per cycle while in_ready_o is high, for header
//   bytes, data bytes and the four bytes of each instruction alike. The
//   parser state and the instruction decoder sit between the parser
//   registers and the output register (or the skid entry, on a stall).
//   Stall: an output register plus one skid entry hold records; while the
//   receiver stalls, requests are still taken until a second record waits
//   in the skid entry, then in_ready_o drops until it drains.
//   Reset: asynchronous, active low; clears the parser to the magic phase
//   and empties the output stage. After an error or the end of a file,
//   bytes are taken and dropped until starts_file is seen.
`default_nettype none

module object_stream_mips_decoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  osmd_pkg::osmd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output osmd_pkg::osmd_rec_t out_data_o
);
  import osmd_pkg::*;

  // parser state
  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  sect_q, sect_d;
  logic        is_text_q, is_text_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] units_q, units_d;
  logic [31:0] word_q, word_d;

  // state seen by this request, after a file restart
  phase_e      phase_e_v;
  logic [1:0]  cnt_v;
  logic [7:0]  sect_v;
  logic        is_text_v;
  logic [31:0] addr_v;
  logic [31:0] units_v;
  logic [31:0] word_v;

  // output stage
  logic        out_valid_q;
  osmd_rec_t   out_data_q;
  logic        skid_valid_q;
  osmd_rec_t   skid_data_q;

  logic        in_fire;
  logic        out_fire;
  logic        rec_valid;
  osmd_rec_t   rec;
  logic [7:0]  b;
  logic [31:0] byte_sh;
  logic [31:0] word_full;
  logic [31:0] units_full;
  logic [31:0] units_new;
  logic [7:0]  magic_exp;
  osmd_dec_t   dec;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_fire    = out_valid_q && out_ready_i;

  // restart on file start
  always_comb begin
    if (in_data_i.starts_file) begin
      phase_e_v = PH_MAGIC;
      cnt_v     = 2'd0;
      sect_v    = 8'd0;
      is_text_v = 1'b0;
      addr_v    = 32'd0;
      units_v   = 32'd0;
      word_v    = 32'd0;
    end else begin
      phase_e_v = phase_q;
      cnt_v     = cnt_q;
      sect_v    = sect_q;
      is_text_v = is_text_q;
      addr_v    = addr_q;
      units_v   = units_q;
      word_v    = word_q;
    end
  end

  // little-endian byte placement
  assign b          = in_data_i.stream_byte;
  assign byte_sh    = {24'd0, b} << {cnt_v, 3'b000};
  assign word_full  = word_v | byte_sh;
  assign units_full = units_v | byte_sh;

  // expected magic byte
  always_comb begin
    case (cnt_v)
      2'd0:    magic_exp = MAGIC_BYTE0;
      2'd1:    magic_exp = MAGIC_BYTE1;
      2'd2:    magic_exp = MAGIC_BYTE2;
      default: magic_exp = MAGIC_BYTE3;
    endcase
  end

  osmd_decode u_decode (
    .word_i (word_full),
    .pc_i   (addr_v),
    .dec_o  (dec)
  );

  // parser next state and record
  always_comb begin
    phase_d   = phase_e_v;
    cnt_d     = cnt_v;
    sect_d    = sect_v;
    is_text_d = is_text_v;
    addr_d    = addr_v;
    units_d   = units_v;
    word_d    = word_v;
    rec_valid = 1'b0;
    rec       = '0;
    units_new = units_full;

    case (phase_e_v)
      PH_MAGIC: begin
        if (b != magic_exp) begin
          phase_d         = PH_STOPPED;
          rec_valid       = 1'b1;
          rec.record_kind = REC_STOPPED;
          rec.error_code  = ERR_MAGIC;
        end else begin
          cnt_d = cnt_v + 2'd1;
          if (cnt_v == 2'd3) begin
            phase_d = PH_VERSION;
          end
        end
      end
      PH_VERSION: begin
        cnt_d = cnt_v + 2'd1;
        if (cnt_v == 2'd1) begin
          phase_d = PH_COUNT;
          cnt_d   = 2'd0;
        end
      end
      PH_COUNT: begin
        sect_d  = b;
        phase_d = (b != 8'd0) ? PH_TYPE : PH_DONE;
      end
      PH_TYPE: begin
        word_d  = {24'd0, b};
        addr_d  = 32'd0;
        cnt_d   = 2'd0;
        phase_d = PH_ADDR;
      end
      PH_ADDR: begin
        addr_d = addr_v | byte_sh;
        cnt_d  = cnt_v + 2'd1;
        if (cnt_v == 2'd3) begin
          phase_d = PH_SIZE;
          units_d = 32'd0;
        end
      end
      PH_SIZE: begin
        units_d = units_full;
        cnt_d   = cnt_v + 2'd1;
        if (cnt_v == 2'd3) begin
          rec_valid        = 1'b1;
          rec.item_address = addr_v;
          if (word_v == SECT_DATA || word_v == SECT_TEXT) begin
            if (word_v == SECT_DATA) begin
              is_text_d       = 1'b0;
              rec.record_kind = REC_DATA_START;
              units_new       = units_full;
            end else begin
              is_text_d       = 1'b1;
              rec.record_kind = REC_TEXT_START;
              units_new       = {2'b00, units_full[31:2]};
            end
            units_d = units_new;
            word_d  = 32'd0;
            phase_d = PH_BODY;
            // empty section ends at once
            if (units_new == 32'd0) begin
              sect_d  = sect_v - 8'd1;
              phase_d = (sect_v != 8'd1) ? PH_TYPE : PH_DONE;
              cnt_d   = 2'd0;
            end
          end else begin
            phase_d         = PH_STOPPED;
            rec.record_kind = REC_STOPPED;
            rec.error_code  = ERR_SECT_TYPE;
          end
        end
      end
      PH_BODY: begin
        if (!is_text_v) begin
          // data byte
          rec_valid        = 1'b1;
          rec.record_kind  = REC_DATA_BYTE;
          rec.item_address = addr_v;
          rec.byte_value   = b;
          addr_d           = addr_v + 32'd1;
          units_d          = units_v - 32'd1;
          if (units_v == 32'd1) begin
            sect_d  = sect_v - 8'd1;
            phase_d = (sect_v != 8'd1) ? PH_TYPE : PH_DONE;
            cnt_d   = 2'd0;
            word_d  = 32'd0;
          end
        end else if (cnt_v != 2'd3) begin
          // gather instruction bytes
          word_d = word_full;
          cnt_d  = cnt_v + 2'd1;
        end else begin
          // full word: decode it
          rec_valid        = 1'b1;
          rec.item_address = addr_v;
          cnt_d            = 2'd0;
          word_d           = 32'd0;
          if (dec.err != ERR_NONE) begin
            rec.record_kind = REC_STOPPED;
            rec.error_code  = dec.err;
            phase_d         = PH_STOPPED;
          end else begin
            rec.record_kind  = REC_INSTR;
            rec.mnemonic     = dec.mnemonic;
            rec.operand_form = dec.form;
            rec.reg_first    = dec.reg_first;
            rec.reg_second   = dec.reg_second;
            rec.reg_third    = dec.reg_third;
            rec.shift_amount = dec.shift_amount;
            rec.immediate    = dec.immediate;
            rec.target       = dec.target;
            addr_d           = addr_v + 32'd4;
            units_d          = units_v - 32'd1;
            if (units_v == 32'd1) begin
              sect_d  = sect_v - 8'd1;
              phase_d = (sect_v != 8'd1) ? PH_TYPE : PH_DONE;
            end
          end
        end
      end
      default: begin
        // stopped or finished: bytes are dropped
      end
    endcase
  end

  // parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC;
      cnt_q     <= 2'd0;
      sect_q    <= 8'd0;
      is_text_q <= 1'b0;
      addr_q    <= 32'd0;
      units_q   <= 32'd0;
      word_q    <= 32'd0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      sect_q    <= sect_d;
      is_text_q <= is_text_d;
      addr_q    <= addr_d;
      units_q   <= units_d;
      word_q    <= word_d;
    end
  end

  // output register and skid entry: valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && rec_valid) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register and skid entry: payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_q <= skid_data_q;
      end
    end else if (in_fire && rec_valid) begin
      if (!out_valid_q || out_fire) begin
        out_data_q <= rec;
      end else begin
        skid_data_q <= rec;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/osmd_decode.sv
// object stream mips decoder: combinational decode of one instruction word
// depends on osmd_pkg for the mnemonic, form and error codes
`default_nettype none

module osmd_decode (
  input  logic [31:0]        word_i,
  input  logic [31:0]        pc_i,
  output osmd_pkg::osmd_dec_t dec_o
);
  import osmd_pkg::*;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  // function codes of the special opcode
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [15:0] imm;
  logic [31:0] br_offset;

  assign op        = word_i[31:26];
  assign fn        = word_i[5:0];
  assign rs        = word_i[25:21];
  assign rt        = word_i[20:16];
  assign rd        = word_i[15:11];
  assign sh        = word_i[10:6];
  assign imm       = word_i[15:0];
  // sign-extended word offset plus the step past the branch itself
  assign br_offset = {{14{imm[15]}}, imm, 2'b00} + 32'd4;

  always_comb begin
    dec_o              = '0;
    dec_o.err          = ERR_NONE;
    dec_o.mnemonic     = MN_ADD;
    dec_o.form         = FORM_NONE;
    dec_o.shift_amount = sh;

    if (op == OP_SPECIAL) begin
      // register-type: pick the mnemonic from the function code
      case (fn)
        FN_ADD:     dec_o.mnemonic = MN_ADD;
        FN_ADDU:    dec_o.mnemonic = MN_ADDU;
        FN_AND:     dec_o.mnemonic = MN_AND;
        FN_NOR:     dec_o.mnemonic = MN_NOR;
        FN_OR:      dec_o.mnemonic = MN_OR;
        FN_SLT:     dec_o.mnemonic = MN_SLT;
        FN_SLTU:    dec_o.mnemonic = MN_SLTU;
        FN_SLL:     dec_o.mnemonic = MN_SLL;
        FN_SRA:     dec_o.mnemonic = MN_SRA;
        FN_SRL:     dec_o.mnemonic = MN_SRL;
        FN_SUB:     dec_o.mnemonic = MN_SUB;
        FN_SUBU:    dec_o.mnemonic = MN_SUBU;
        FN_XOR:     dec_o.mnemonic = MN_XOR;
        FN_JR:      dec_o.mnemonic = MN_JR;
        FN_SYSCALL: dec_o.mnemonic = MN_SYSCALL;
        default:    dec_o.err      = ERR_UNKNOWN_OP;
      endcase

      // field rules and operand layout
      if (dec_o.err == ERR_NONE) begin
        case (dec_o.mnemonic)
          MN_SYSCALL: dec_o.form = FORM_NONE;
          MN_SLL, MN_SRA, MN_SRL: begin
            if (rs != 5'd0) begin
              dec_o.err = ERR_RS_NZ;
            end else if (sh == 5'd0) begin
              dec_o.err = ERR_SHAMT_ZERO;
            end else begin
              dec_o.form       = FORM_SHIFT;
              dec_o.reg_first  = rd;
              dec_o.reg_second = rt;
            end
          end
          MN_JR: begin
            if (rt != 5'd0 || rd != 5'd0 || sh != 5'd0) begin
              dec_o.err = ERR_JR_FIELDS;
            end else begin
              dec_o.form      = FORM_RS;
              dec_o.reg_first = rs;
            end
          end
          default: begin
            if (sh != 5'd0) begin
              dec_o.err = ERR_SHAMT_NZ;
            end else begin
              dec_o.form       = FORM_THREE;
              dec_o.reg_first  = rd;
              dec_o.reg_second = rs;
              dec_o.reg_third  = rt;
            end
          end
        endcase
      end
    end else if (op == OP_J || op == OP_JAL) begin
      // jump: word index shifted into a 28-bit byte target
      dec_o.mnemonic = (op == OP_J) ? MN_J : MN_JAL;
      dec_o.form     = FORM_JUMP;
      dec_o.target   = {4'b0000, word_i[25:0], 2'b00};
    end else begin
      // immediate-type
      case (op)
        OP_ADDI:  dec_o.mnemonic = MN_ADDI;
        OP_ADDIU: dec_o.mnemonic = MN_ADDIU;
        OP_ANDI:  dec_o.mnemonic = MN_ANDI;
        OP_LUI:   dec_o.mnemonic = MN_LUI;
        OP_ORI:   dec_o.mnemonic = MN_ORI;
        OP_SLTI:  dec_o.mnemonic = MN_SLTI;
        OP_SLTIU: dec_o.mnemonic = MN_SLTIU;
        OP_LBU:   dec_o.mnemonic = MN_LBU;
        OP_LHU:   dec_o.mnemonic = MN_LHU;
        OP_LW:    dec_o.mnemonic = MN_LW;
        OP_SB:    dec_o.mnemonic = MN_SB;
        OP_SH:    dec_o.mnemonic = MN_SH;
        OP_SW:    dec_o.mnemonic = MN_SW;
        OP_BEQ:   dec_o.mnemonic = MN_BEQ;
        OP_BNE:   dec_o.mnemonic = MN_BNE;
        default:  dec_o.err      = ERR_UNKNOWN_OP;
      endcase

      if (dec_o.err == ERR_NONE) begin
        dec_o.immediate  = imm;
        dec_o.reg_first  = rt;
        dec_o.reg_second = rs;
        case (dec_o.mnemonic)
          MN_BEQ, MN_BNE: begin
            dec_o.form   = FORM_BRANCH;
            dec_o.target = pc_i + br_offset;
          end
          MN_LBU, MN_LHU, MN_LW, MN_SB, MN_SH, MN_SW: dec_o.form = FORM_LDST;
          MN_LUI: begin
            if (rs != 5'd0) begin
              dec_o.err = ERR_RS_NZ;
            end
            dec_o.form       = FORM_LUI;
            dec_o.reg_second = 5'd0;
          end
          MN_ANDI, MN_ORI: dec_o.form = FORM_HEX_IMM;
          default:         dec_o.form = FORM_SIGN_IMM;
        endcase
      end
    end
  end

endmodule

`default_nettype wire
